>>> design/lgdm_pkg.sv
package lgdm_pkg;

    localparam int GLYPH_SLOTS_DEF = 8;
    localparam int CELL_ROWS_DEF   = 8;
    localparam int CELL_COLS_DEF   = 5;

    localparam int IN_ROWS    = 8;
    localparam int ROW_W      = 5;
    localparam int ROWS_W     = IN_ROWS * ROW_W;
    localparam int SLOT_W     = 3;
    localparam int S_DATA_W   = ((ROWS_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((SLOT_W + 7) / 8) * 8;
    localparam int M_USER_W   = 3;

    typedef struct packed {
        logic frame_start;
        logic blank;
    } t_flags;

    typedef struct packed {
        logic              overflow;
        logic              new_glyph;
        logic [SLOT_W-1:0] slot;
        logic              is_blank;
    } t_result;

    function automatic int min_int(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

endpackage

>>> design/lcd_glyph_dedup_mapper.sv
// channel   dir  tdata                                tuser
// s (cell)  in   row0_bits..row7_bits, 5 bits each    frame_start
// m (map)   out  slot_index                           is_blank, new_glyph, table_overflow
//
// a blank cell, or the first glyph after an empty table, is resolved in the scan engine without a scan
// any other cell is compared with the stored glyphs in order, one per cycle, until a hit or the last (k <= slots)
// before the scan engine, each cell passes through the classify register and the two-entry queue
// reset clears the slot count, queue and valid flags; glyph contents need no clearing
// the front keeps taking cells into the queue while a result waits on i_m_tready, until the queue is full
module lcd_glyph_dedup_mapper import lgdm_pkg::*; #(
    parameter int GLYPH_SLOTS = GLYPH_SLOTS_DEF,
    parameter int CELL_ROWS   = CELL_ROWS_DEF,
    parameter int CELL_COLS   = CELL_COLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // row0_bits .. row7_bits
    input  logic                i_s_tuser,   // frame_start
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // slot_index
    output logic [M_USER_W-1:0] o_m_tuser    // is_blank, new_glyph, table_overflow
);

    localparam int CELL_W = min_int(CELL_ROWS, IN_ROWS) * min_int(CELL_COLS, ROW_W);
    localparam int Q_W    = $bits(t_flags) + CELL_W;

    logic              f_valid;
    logic              f_ready;
    t_flags            f_flags;
    logic [CELL_W-1:0] f_cell;
    logic              q_valid;
    logic              q_ready;
    logic [Q_W-1:0]    q_data;
    t_result           result;

    lgdm_front #(
        .CELL_ROWS (CELL_ROWS),
        .CELL_COLS (CELL_COLS),
        .CELL_W    (CELL_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_frame_start (i_s_tuser),
        .i_rows        (i_s_tdata[ROWS_W-1:0]),
        .o_valid       (f_valid),
        .i_ready       (f_ready),
        .o_flags       (f_flags),
        .o_cell        (f_cell)
    );

    lgdm_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  ({f_flags, f_cell}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    lgdm_back #(
        .GLYPH_SLOTS (GLYPH_SLOTS),
        .CELL_W      (CELL_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_ready  (q_ready),
        .i_flags  (t_flags'(q_data[Q_W-1:CELL_W])),
        .i_cell   (q_data[CELL_W-1:0]),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (result)
    );

    assign o_m_tdata = M_DATA_W'(result.slot);
    assign o_m_tuser = {result.overflow, result.new_glyph, result.is_blank};

endmodule

>>> design/lgdm_front.sv
module lgdm_front import lgdm_pkg::*; #(
    parameter int CELL_ROWS = CELL_ROWS_DEF,
    parameter int CELL_COLS = CELL_COLS_DEF,
    parameter int CELL_W    = min_int(CELL_ROWS, IN_ROWS) * min_int(CELL_COLS, ROW_W)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_frame_start,
    input  logic [ROWS_W-1:0] i_rows,
    output logic              o_valid,
    input  logic              i_ready,
    output t_flags            o_flags,
    output logic [CELL_W-1:0] o_cell
);

    localparam int ER = min_int(CELL_ROWS, IN_ROWS);
    localparam int EC = min_int(CELL_COLS, ROW_W);

    logic              r_valid;
    t_flags            r_flags;
    logic [CELL_W-1:0] r_cell;
    logic [CELL_W-1:0] n_cell;

    // keep the used columns of each used row
    always_comb begin
        for (int r = 0; r < ER; r++) begin
            n_cell[r*EC +: EC] = i_rows[r*ROW_W +: EC];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_flags.frame_start <= i_frame_start;
            r_flags.blank       <= ~|n_cell;
            r_cell              <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_cell  = r_cell;

endmodule

>>> design/lgdm_queue.sv
module lgdm_queue import lgdm_pkg::*; #(
    parameter int DATA_W = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              push;
    logic              pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = i_ready && o_valid;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> design/lgdm_back.sv
module lgdm_back import lgdm_pkg::*; #(
    parameter int GLYPH_SLOTS = GLYPH_SLOTS_DEF,
    parameter int CELL_W      = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_flags            i_flags,
    input  logic [CELL_W-1:0] i_cell,
    output logic              o_valid,
    input  logic              i_ready,
    output t_result           o_result
);

    localparam int SW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
    localparam int UW = $clog2(GLYPH_SLOTS + 1);
    localparam logic [UW-1:0] SLOTS_U = UW'(GLYPH_SLOTS);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state            r_state;
    logic [UW-1:0]     r_used;
    logic [SW-1:0]     r_idx;
    logic [CELL_W-1:0] r_cell;
    logic              r_out_valid;
    t_result           r_result;

    logic [CELL_W-1:0] r_store [GLYPH_SLOTS];
    logic [CELL_W-1:0] r_rd_data;

    logic              out_free;
    logic              pop;
    logic [UW-1:0]     eff_used;
    logic              hit;
    logic              last;
    logic [SW-1:0]     rd_addr;
    logic              we;
    logic [SW-1:0]     waddr;
    logic [CELL_W-1:0] wdata;

    assign out_free = !r_out_valid || i_ready;
    assign pop      = (r_state == S_IDLE) && i_valid && out_free;
    assign eff_used = i_flags.frame_start ? '0 : r_used;
    assign hit      = (r_rd_data == r_cell);
    assign last     = ((UW'(r_idx) + UW'(1)) == r_used);

    always_comb begin
        rd_addr = '0;
        we      = 1'b0;
        waddr   = SW'(r_used);
        wdata   = r_cell;
        case (r_state)
            S_IDLE: begin
                if (pop && !i_flags.blank && eff_used == '0) begin
                    we    = 1'b1;
                    waddr = '0;
                    wdata = i_cell;
                end
            end
            S_SCAN: begin
                rd_addr = (!hit && !last) ? r_idx + SW'(1) : r_idx;
                if (!hit && last && out_free && r_used < SLOTS_U) begin
                    we = 1'b1;
                end
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_store[waddr] <= wdata;
        end
        r_rd_data <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_cell <= i_cell;
                        r_idx  <= '0;
                        if (i_flags.blank) begin
                            r_used      <= eff_used;
                            r_out_valid <= 1'b1;
                            r_result    <= '{overflow: 1'b0, new_glyph: 1'b0,
                                             slot: '0, is_blank: 1'b1};
                        end else if (eff_used == '0) begin
                            r_used      <= UW'(1);
                            r_out_valid <= 1'b1;
                            r_result    <= '{overflow: 1'b0, new_glyph: 1'b1,
                                             slot: '0, is_blank: 1'b0};
                        end else begin
                            r_used  <= eff_used;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (hit && out_free) begin
                        r_out_valid <= 1'b1;
                        r_result    <= '{overflow: 1'b0, new_glyph: 1'b0,
                                         slot: SLOT_W'(r_idx), is_blank: 1'b0};
                        r_state     <= S_IDLE;
                    end else if (!hit && last && out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_used < SLOTS_U) begin
                            r_used   <= r_used + UW'(1);
                            r_result <= '{overflow: 1'b0, new_glyph: 1'b1,
                                          slot: SLOT_W'(r_used), is_blank: 1'b0};
                        end else begin
                            r_result <= '{overflow: 1'b1, new_glyph: 1'b0,
                                          slot: '0, is_blank: 1'b0};
                        end
                    end else if (!hit && !last) begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready  = pop;
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

>>> design/lgdm_checker.sv
module lgdm_checker import lgdm_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] i_m_tdata,
    input logic [M_USER_W-1:0] i_m_tuser
);

    // blank cells never store a glyph; they report slot 0 with no new_glyph or overflow flag
    a_blank_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[0] |->
            i_m_tdata[SLOT_W-1:0] == '0 && !i_m_tuser[1] && !i_m_tuser[2])
        else $error("blank cell with slot or flags");

    a_new_or_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> !(i_m_tuser[1] && i_m_tuser[2]))
        else $error("new glyph and overflow together");

    a_over_slot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[2] |-> i_m_tdata[SLOT_W-1:0] == '0)
        else $error("overflow not mapped to slot 0");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=>
            i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result changed while stalled");

endmodule

bind lcd_glyph_dedup_mapper lgdm_checker u_lgdm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);
